/* rtl/gb3_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package gb3_pkg;

  localparam int ROW_W = 11;
  localparam int COEF_W = 16;
  localparam int COEF_FRAC_BITS = 16;
  localparam logic [ROW_W-1:0] MAX_HEIGHT = 11'd1024;

  // configuration register indexes
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_COEF_CORNER  = 3'd2;
  localparam logic [2:0] REG_COEF_EDGE    = 3'd3;
  localparam logic [2:0] REG_COEF_CENTER  = 3'd4;

  localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd512;
  localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd512;
  localparam logic [15:0] RST_COEF_CORNER  = 16'd5102;
  localparam logic [15:0] RST_COEF_EDGE    = 16'd8082;
  localparam logic [15:0] RST_COEF_CENTER  = 16'd12802;

  typedef struct packed {
    logic [10:0] image_width;
    logic [10:0] image_height;
    logic [15:0] coef_corner;
    logic [15:0] coef_edge;
    logic [15:0] coef_center;
  } gb3_cfg_t;

  // per-item control from the position sequencer
  typedef struct packed {
    logic       emit;
    logic       last;
    logic       clear;
    logic [2:0] rmask;
    logic [2:0] cmask;
  } gb3_pos_t;

  // masked neighborhood sums, channel 2 red, 1 green, 0 blue
  typedef struct packed {
    logic            last;
    logic [2:0][9:0] corner;
    logic [2:0][9:0] side;
    logic [2:0][7:0] center;
  } gb3_sums_t;

endpackage
`default_nettype wire

/* rtl/gb3_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface gb3_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, cmd, red_in, green_in, blue_in, input ready);
  modport sink (input valid, cmd, red_in, green_in, blue_in, output ready);
endinterface
`default_nettype wire

/* rtl/gb3_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface gb3_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       frame_last;

  modport source (output valid, red_out, green_out, blue_out, frame_last, input ready);
  modport sink (input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface
`default_nettype wire

/* rtl/gb3_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module gb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/gb3_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module gb3_ctrl
  import gb3_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  localparam int CW = $clog2(MAX_WIDTH + 1)
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire gb3_cfg_t    cfg,
  input  wire logic        accept,
  output logic [CW-1:0]    x,
  output gb3_pos_t         pos
);

  logic [CW-1:0]    in_col;
  logic [ROW_W-1:0] in_row;
  logic [CW-1:0]    out_col;
  logic [ROW_W-1:0] out_row;

  logic [CW-1:0]    in_col_next;
  logic [ROW_W-1:0] in_row_next;
  logic [CW-1:0]    out_col_next;
  logic [ROW_W-1:0] out_row_next;

  logic [31:0]      w_req;
  logic [CW-1:0]    w;
  logic [ROW_W-1:0] h;
  logic             wrap;
  logic [ROW_W-1:0] row_a;
  logic [ROW_W-1:0] row_b;
  logic [CW:0]      ic1;
  logic [CW:0]      oc1;
  logic [ROW_W:0]   rpos [3];
  logic [CW:0]      cpos [3];
  logic             restart;

  always_comb begin
    w_req = 32'(cfg.image_width);
    if (w_req == 32'd0) begin
      w = CW'(1);
    end else if (w_req > 32'(MAX_WIDTH)) begin
      w = CW'(MAX_WIDTH);
    end else begin
      w = CW'(w_req);
    end
    if (cfg.image_height == '0) begin
      h = ROW_W'(1);
    end else if (cfg.image_height > MAX_HEIGHT) begin
      h = MAX_HEIGHT;
    end else begin
      h = cfg.image_height;
    end
  end

  always_comb begin
    wrap  = (in_col >= w);
    x     = wrap ? '0 : in_col;
    row_a = in_row + ROW_W'(wrap);

    pos.emit  = (row_a != '0 && x != '0) || (row_a > ROW_W'(1));
    pos.last  = pos.emit && (out_row >= h - ROW_W'(1)) && (out_col >= w - CW'(1));

    // neighbor rows and columns of the output pixel that fall inside the frame
    for (int d = 0; d < 3; d++) begin
      rpos[d] = {1'b0, out_row} + (ROW_W+1)'(d);
      cpos[d] = {1'b0, out_col} + (CW+1)'(d);
      pos.rmask[d] = (rpos[d] != '0) && (rpos[d] <= {1'b0, h});
      pos.cmask[d] = (cpos[d] != '0) && (cpos[d] <= {1'b0, w});
    end

    out_col_next = out_col;
    out_row_next = out_row;
    oc1 = {1'b0, out_col} + (CW+1)'(1);
    if (pos.emit) begin
      if (oc1 >= {1'b0, w}) begin
        out_col_next = '0;
        out_row_next = out_row + ROW_W'(1);
      end else begin
        out_col_next = oc1[CW-1:0];
      end
    end

    ic1 = {1'b0, x} + (CW+1)'(1);
    row_b = row_a;
    if (ic1 >= {1'b0, w}) begin
      in_col_next = '0;
      row_b       = row_a + ROW_W'(1);
    end else begin
      in_col_next = ic1[CW-1:0];
    end
    in_row_next = row_b;

    restart = pos.last || ({1'b0, row_b} > ({1'b0, h} + (ROW_W+1)'(1)))
              || (out_row_next >= h);
    pos.clear = restart;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (accept) begin
      if (restart) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        in_col  <= in_col_next;
        in_row  <= in_row_next;
        out_col <= out_col_next;
        out_row <= out_row_next;
      end
    end
  end

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && pos.last |=> in_col == '0 && in_row == '0 && out_col == '0 && out_row == '0)
    else $error("counters not cleared after last pixel of frame");

  a_no_result_on_first_row: assert property (@(posedge clk) disable iff (rst)
    accept && in_row == '0 && in_col == '0 |-> !pos.emit)
    else $error("result issued before the window holds the first pixel");

endmodule
`default_nettype wire

/* rtl/gb3_window.sv */
`timescale 1ns / 1ps
`default_nettype none
module gb3_window
  import gb3_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  localparam int CW = $clog2(MAX_WIDTH + 1),
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic [CW-1:0] x,
  input  wire gb3_pos_t      pos,
  input  wire logic [23:0]   px,
  input  wire logic          mac_ready,
  output logic               ready,
  output logic               sums_valid,
  output gb3_sums_t          sums
);

  logic                  s1_v;
  logic [CW-1:0]         s1_x;
  gb3_pos_t              s1_pos;
  logic [23:0]           s1_px;
  logic                  s1_done;

  logic                  fwd_hit;
  logic [23:0]           fwd_up;
  logic [23:0]           fwd_mid;

  logic [23:0]           up_rd;
  logic [23:0]           mid_rd;
  logic [23:0]           up_q;
  logic [23:0]           mid_q;

  logic [2:0][2:0][23:0] win;
  logic [2:0][2:0][23:0] sh;
  logic [2:0][2:0][23:0] msk;

  gb3_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (s1_done),
    .waddr (s1_x[AW-1:0]),
    .wdata (mid_q),
    .re    (accept),
    .raddr (x[AW-1:0]),
    .rdata (up_rd)
  );

  gb3_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (s1_done),
    .waddr (s1_x[AW-1:0]),
    .wdata (s1_px),
    .re    (accept),
    .raddr (x[AW-1:0]),
    .rdata (mid_rd)
  );

  // the item ahead writes the same column in the cycle this one reads it
  assign up_q  = fwd_hit ? fwd_up : up_rd;
  assign mid_q = fwd_hit ? fwd_mid : mid_rd;

  assign s1_done    = s1_v && (!s1_pos.emit || mac_ready);
  assign ready      = !s1_v || s1_done;
  assign sums_valid = s1_v && s1_pos.emit;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sh[r][0] = win[r][1];
      sh[r][1] = win[r][2];
    end
    sh[0][2] = up_q;
    sh[1][2] = mid_q;
    sh[2][2] = s1_px;

    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        msk[r][k] = (s1_pos.rmask[r] && s1_pos.cmask[k]) ? sh[r][k] : '0;
      end
    end

    sums.last = s1_pos.last;
    for (int c = 0; c < 3; c++) begin
      sums.corner[c] = 10'(msk[0][0][8*c +: 8]) + 10'(msk[0][2][8*c +: 8])
                     + 10'(msk[2][0][8*c +: 8]) + 10'(msk[2][2][8*c +: 8]);
      sums.side[c]   = 10'(msk[0][1][8*c +: 8]) + 10'(msk[1][0][8*c +: 8])
                     + 10'(msk[1][2][8*c +: 8]) + 10'(msk[2][1][8*c +: 8]);
      sums.center[c] = msk[1][1][8*c +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v    <= 1'b0;
      fwd_hit <= 1'b0;
      win     <= '0;
    end else begin
      if (accept) begin
        s1_v    <= 1'b1;
        fwd_hit <= s1_done && (s1_x == x);
      end else if (s1_done) begin
        s1_v <= 1'b0;
      end
      if (s1_done) begin
        win <= s1_pos.clear ? '0 : sh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x    <= x;
      s1_pos  <= pos;
      s1_px   <= px;
      fwd_up  <= mid_q;
      fwd_mid <= s1_px;
    end
  end

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_v)
    else $error("accepted pixel missing from window stage");

  a_clear_empties_window: assert property (@(posedge clk) disable iff (rst)
    s1_done && s1_pos.clear |=> win == '0)
    else $error("window not cleared at frame restart");

endmodule
`default_nettype wire

/* rtl/gb3_mac.sv */
`timescale 1ns / 1ps
`default_nettype none
module gb3_mac
  import gb3_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire gb3_cfg_t  cfg,
  input  wire logic      in_valid,
  input  wire gb3_sums_t sums,
  output logic           in_ready,
  gb3_out_if.source      pix_out
);

  logic            s2_v;
  gb3_sums_t       s2;
  logic            s3_v;
  logic [2:0][25:0] p_corner;
  logic [2:0][25:0] p_side;
  logic [2:0][23:0] p_center;
  logic            s3_last;

  logic            o_v;
  logic [2:0][7:0] o_rgb;
  logic            o_last;

  logic            o_free;
  logic            s3_free;
  logic [2:0][7:0] rgb_next;
  logic [27:0]     acc;
  logic [27:0]     scaled;

  assign o_free   = !o_v || pix_out.ready;
  assign s3_free  = !s3_v || o_free;
  assign in_ready = !s2_v || s3_free;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc = 28'(p_corner[c]) + 28'(p_side[c]) + 28'(p_center[c]);
      scaled = acc >> COEF_FRAC_BITS;
      rgb_next[c] = (scaled > 28'd255) ? 8'd255 : scaled[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      o_v  <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s2_v <= 1'b1;
      end else if (s3_free) begin
        s2_v <= 1'b0;
      end
      if (s2_v && s3_free) begin
        s3_v <= 1'b1;
      end else if (o_free) begin
        s3_v <= 1'b0;
      end
      if (s3_v && o_free) begin
        o_v <= 1'b1;
      end else if (pix_out.ready) begin
        o_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s2 <= sums;
    end
    if (s2_v && s3_free) begin
      for (int c = 0; c < 3; c++) begin
        p_corner[c] <= 26'(s2.corner[c]) * 26'(cfg.coef_corner);
        p_side[c]   <= 26'(s2.side[c]) * 26'(cfg.coef_edge);
        p_center[c] <= 24'(s2.center[c]) * 24'(cfg.coef_center);
      end
      s3_last <= s2.last;
    end
    if (s3_v && o_free) begin
      o_rgb  <= rgb_next;
      o_last <= s3_last;
    end
  end

  assign pix_out.valid      = o_v;
  assign pix_out.red_out    = o_rgb[2];
  assign pix_out.green_out  = o_rgb[1];
  assign pix_out.blue_out   = o_rgb[0];
  assign pix_out.frame_last = o_last;

  a_product_held: assert property (@(posedge clk) disable iff (rst)
    s3_v && !o_free |=> s3_v)
    else $error("product stage dropped while output blocked");

endmodule
`default_nettype wire

/* rtl/gaussian_blur_3x3_rgb_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// 3x3 gaussian blur of a 24-bit rgb pixel stream in raster order.
// pix_in carries cmd and one pixel per transfer; cmd 1 is a flush tick
// (black inside the frame, drain after it). after the last pixel of a frame
// send image_width+1 flush ticks to drain the bottom row.
// pix_out carries the filtered pixel and frame_last on the final pixel.
// results trail the input by one row plus one pixel: no result until the
// input reaches row 1, column 1, then one result per transfer.
// one pixel per cycle sustained unless pix_out stalls; each column is read
// and written back once per pixel in the two line stores, with forwarding
// when the same column repeats in consecutive cycles (one-pixel-wide frames).
// a result passes the window stage, then the sum, product and output
// registers of the filter, before pix_out valid rises for it.
// when the receiver stalls, up to four results wait inside (window stage
// plus three filter stages) and pix_in ready drops once those are full.
// reset clears counters, window and pipeline; line stores need no clearing
// and configuration returns to 512x512 with the default kernel.
// configure through cfg_write/cfg_index/cfg_data only while idle.
module gaussian_blur_3x3_rgb_unit
  import gb3_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  gb3_in_if.sink           pix_in,
  gb3_out_if.source        pix_out
);

  localparam int CW = $clog2(MAX_WIDTH + 1);

  gb3_cfg_t      cfg;
  logic          accept;
  logic [CW-1:0] x;
  gb3_pos_t      pos;
  logic [23:0]   px;
  logic          win_ready;
  logic          mac_ready;
  logic          sums_valid;
  gb3_sums_t     sums;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= RST_IMAGE_WIDTH;
      cfg.image_height <= RST_IMAGE_HEIGHT;
      cfg.coef_corner  <= RST_COEF_CORNER;
      cfg.coef_edge    <= RST_COEF_EDGE;
      cfg.coef_center  <= RST_COEF_CENTER;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data[10:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data[10:0];
        REG_COEF_CORNER:  cfg.coef_corner  <= cfg_data;
        REG_COEF_EDGE:    cfg.coef_edge    <= cfg_data;
        REG_COEF_CENTER:  cfg.coef_center  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pix_in.ready = win_ready;
  assign accept       = pix_in.valid && win_ready;
  assign px = pix_in.cmd ? 24'd0 : {pix_in.red_in, pix_in.green_in, pix_in.blue_in};

  gb3_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .x      (x),
    .pos    (pos)
  );

  gb3_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .x          (x),
    .pos        (pos),
    .px         (px),
    .mac_ready  (mac_ready),
    .ready      (win_ready),
    .sums_valid (sums_valid),
    .sums       (sums)
  );

  gb3_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (sums_valid),
    .sums     (sums),
    .in_ready (mac_ready),
    .pix_out  (pix_out)
  );

endmodule
`default_nettype wire

/* tb/tb_gaussian_blur_3x3_rgb_unit.sv */
`timescale 1ns / 1ps
module tb_gaussian_blur_3x3_rgb_unit;
  import gb3_pkg::*;

  localparam int LINE_MAX = 1024;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_ITEMS = 900;
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef enum int {IDLE_NONE, IDLE_SOME, IDLE_HEAVY} idle_mode_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_last;
  } blur_pixel_t;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  gb3_in_if  pix_in ();
  gb3_out_if pix_out ();

  gaussian_blur_3x3_rgb_unit #(
    .MAX_WIDTH(LINE_MAX)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pix_in(pix_in),
    .pix_out(pix_out)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // filter model state
  logic [10:0] width_reg;
  logic [10:0] height_reg;
  logic [15:0] w_corner;
  logic [15:0] w_side;
  logic [15:0] w_center;
  logic [23:0] prev2_line [LINE_MAX];
  logic [23:0] prev1_line [LINE_MAX];
  logic [23:0] nbhd [3][3];
  int unsigned src_col, src_row, dst_col, dst_row;

  blur_pixel_t filtered_expected[$];
  pixel_item_t pix_pending[$];
  int unsigned pix_queued, pix_taken;
  int unsigned pixels_checked, frames_seen, setups;
  int          fail_count;
  idle_mode_e  src_mode, snk_mode;
  int unsigned src_wait, snk_wait, snk_draw;
  pixel_item_t next_item, seen_item;
  blur_pixel_t want;

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > LINE_MAX) return LINE_MAX;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return height_reg;
  endfunction

  function automatic void restart_window();
    int i, j;
    for (i = 0; i < 3; i++)
      for (j = 0; j < 3; j++)
        nbhd[i][j] = 24'h0;
    src_col = 0;
    src_row = 0;
    dst_col = 0;
    dst_row = 0;
  endfunction

  // weighted 3x3 sum of one channel, rows and columns outside the frame dropped
  function automatic logic [7:0] channel_blur(int sh, int unsigned w, int unsigned h);
    logic [39:0] acc;
    int unsigned rr, cc;
    logic [15:0] wt;
    int dr, dc;
    acc = '0;
    for (dr = 0; dr < 3; dr++) begin
      rr = dst_row + dr;
      if (rr >= 1 && rr <= h) begin
        for (dc = 0; dc < 3; dc++) begin
          cc = dst_col + dc;
          if (cc >= 1 && cc <= w) begin
            if (dr != 1 && dc != 1) wt = w_corner;
            else if (dr != 1 || dc != 1) wt = w_side;
            else wt = w_center;
            acc += ((nbhd[dr][dc] >> sh) & 24'hFF) * wt;
          end
        end
      end
    end
    acc = acc >> COEF_FRAC_BITS;
    return (acc > 40'd255) ? 8'hFF : acc[7:0];
  endfunction

  function automatic void advance_filter(pixel_item_t it);
    int unsigned w, h, x;
    logic [23:0] px, up, mid;
    blur_pixel_t res;
    int i;
    w = eff_width();
    h = eff_height();
    if (src_col >= w) begin
      src_col = 0;
      src_row++;
    end
    x = src_col;
    px = (it.cmd == CMD_PIXEL) ? {it.red, it.green, it.blue} : 24'h0;
    up = prev2_line[x];
    mid = prev1_line[x];
    prev2_line[x] = mid;
    prev1_line[x] = px;
    for (i = 0; i < 3; i++) begin
      nbhd[i][0] = nbhd[i][1];
      nbhd[i][1] = nbhd[i][2];
    end
    nbhd[0][2] = up;
    nbhd[1][2] = mid;
    nbhd[2][2] = px;
    if ((src_row >= 1 && x >= 1) || src_row >= 2) begin
      res.red = channel_blur(16, w, h);
      res.green = channel_blur(8, w, h);
      res.blue = channel_blur(0, w, h);
      res.frame_last = (dst_row >= h - 1 && dst_col >= w - 1);
      filtered_expected.push_back(res);
      if (res.frame_last) begin
        restart_window();
        return;
      end
      dst_col++;
      if (dst_col >= w) begin
        dst_col = 0;
        dst_row++;
      end
    end
    src_col++;
    if (src_col >= w) begin
      src_col = 0;
      src_row++;
    end
    // position ran past the frame, e.g. after the height shrank
    if (src_row > h + 1 || dst_row >= h) restart_window();
  endfunction

  function automatic int unsigned draw_wait(idle_mode_e mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_SOME: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 17) : 0;
      default: return $urandom_range(0, 17);
    endcase
  endfunction

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] pick_coef();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 12000));
      2: return ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
      default: return 16'($urandom_range(2000, 16000));
    endcase
  endfunction

  function automatic void check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endfunction

  // source side: one transfer per item, then the drawn gap
  always @(posedge clk) begin
    if (rst) begin
      pix_in.valid <= 1'b0;
      src_wait <= 0;
    end else if (!pix_in.valid || pix_in.ready) begin
      if (src_wait != 0) begin
        pix_in.valid <= 1'b0;
        src_wait <= src_wait - 1;
      end else if (pix_pending.size() != 0) begin
        next_item = pix_pending.pop_front();
        pix_in.valid <= 1'b1;
        pix_in.cmd <= next_item.cmd;
        pix_in.red_in <= next_item.red;
        pix_in.green_in <= next_item.green;
        pix_in.blue_in <= next_item.blue;
        src_wait <= draw_wait(src_mode);
      end else begin
        pix_in.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pix_in.valid && pix_in.ready) begin
      seen_item = {pix_in.cmd, pix_in.red_in, pix_in.green_in, pix_in.blue_in};
      advance_filter(seen_item);
      pix_taken++;
    end
  end

  // sink side: after a transfer, hold ready low for the drawn wait
  always @(posedge clk) begin
    if (rst) begin
      pix_out.ready <= 1'b0;
      snk_wait <= 0;
    end else if (pix_out.valid && pix_out.ready) begin
      snk_draw = draw_wait(snk_mode);
      snk_wait <= snk_draw;
      pix_out.ready <= (snk_draw == 0);
    end else if (snk_wait != 0) begin
      snk_wait <= snk_wait - 1;
      pix_out.ready <= (snk_wait == 1);
    end else begin
      pix_out.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && pix_out.valid && pix_out.ready) begin
      if (filtered_expected.size() == 0) begin
        $error("filtered pixel with none expected: rgb %0d %0d %0d last %0d",
               pix_out.red_out, pix_out.green_out, pix_out.blue_out, pix_out.frame_last);
        fail_count++;
      end else begin
        want = filtered_expected.pop_front();
        check_field("red_out", want.red, pix_out.red_out);
        check_field("green_out", want.green, pix_out.green_out);
        check_field("blue_out", want.blue, pix_out.blue_out);
        check_field("frame_last", 8'(want.frame_last), 8'(pix_out.frame_last));
        pixels_checked++;
        if (want.frame_last) frames_seen++;
      end
    end
  end

  task automatic push_item(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pixel_item_t it;
    it.cmd = cmd;
    it.red = r;
    it.green = g;
    it.blue = b;
    pix_pending.push_back(it);
    pix_queued++;
  endtask

  // full frame with occasional black ticks inside and data-bearing pixels in the drain
  task automatic push_frame(int unsigned w, int unsigned h);
    int unsigned i;
    for (i = 0; i < w * h; i++)
      push_item(($urandom_range(0, 15) == 0) ? CMD_FLUSH : CMD_PIXEL,
                pick_level(), pick_level(), pick_level());
    for (i = 0; i <= w; i++)
      push_item(($urandom_range(0, 3) == 0) ? CMD_PIXEL : CMD_FLUSH,
                pick_level(), pick_level(), pick_level());
  endtask

  task automatic settle();
    while (pix_taken != pix_queued || filtered_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // cfg_write stays high across back-to-back writes, end_writes drops it
  task automatic set_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_IMAGE_WIDTH: width_reg = val[10:0];
      REG_IMAGE_HEIGHT: height_reg = val[10:0];
      REG_COEF_CORNER: w_corner = val;
      REG_COEF_EDGE: w_side = val;
      REG_COEF_CENTER: w_center = val;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_write <= 1'b0;
    setups++;
  endtask

  task automatic program_regs(logic [15:0] w, logic [15:0] h, logic [15:0] kc,
                              logic [15:0] ks, logic [15:0] km);
    set_reg(REG_IMAGE_WIDTH, w);
    set_reg(REG_IMAGE_HEIGHT, h);
    set_reg(REG_COEF_CORNER, kc);
    set_reg(REG_COEF_EDGE, ks);
    set_reg(REG_COEF_CENTER, km);
    end_writes();
  endtask

  // pad a partial frame with flush ticks so the next setup starts clean
  task automatic close_frame();
    int unsigned w, h, remaining;
    settle();
    if (src_row != 0 || src_col != 0) begin
      w = eff_width();
      h = eff_height();
      remaining = (h + 1) * w + 1 - (src_row * w + src_col);
      repeat (remaining) push_item(CMD_FLUSH, pick_level(), pick_level(), pick_level());
      settle();
    end
  endtask

  initial begin
    int unsigned random_start, frames, i;
    logic [15:0] w_pick, h_pick;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pix_in.valid = 1'b0;
    pix_in.cmd = CMD_PIXEL;
    pix_in.red_in = '0;
    pix_in.green_in = '0;
    pix_in.blue_in = '0;
    pix_out.ready = 1'b0;
    pix_queued = 0;
    pix_taken = 0;
    pixels_checked = 0;
    frames_seen = 0;
    setups = 0;
    fail_count = 0;
    src_mode = IDLE_SOME;
    snk_mode = IDLE_SOME;
    width_reg = RST_IMAGE_WIDTH;
    height_reg = RST_IMAGE_HEIGHT;
    w_corner = RST_COEF_CORNER;
    w_side = RST_COEF_EDGE;
    w_center = RST_COEF_CENTER;
    for (i = 0; i < LINE_MAX; i++) begin
      prev2_line[i] = 24'h0;
      prev1_line[i] = 24'h0;
    end
    restart_window();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // 3x2 frame on the reset kernel: extremes, black tick inside, pixel in the drain
    set_reg(REG_IMAGE_WIDTH, 16'd3);
    set_reg(REG_IMAGE_HEIGHT, 16'd2);
    end_writes();
    push_item(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    push_item(CMD_PIXEL, 8'h00, 8'h00, 8'h00);
    push_item(CMD_PIXEL, 8'hFF, 8'h00, 8'h80);
    push_item(CMD_FLUSH, 8'h80, 8'hFF, 8'h00);
    push_item(CMD_PIXEL, 8'h01, 8'h02, 8'h03);
    push_item(CMD_PIXEL, 8'hFE, 8'hFD, 8'hFC);
    push_item(CMD_FLUSH, 8'h00, 8'h00, 8'h00);
    push_item(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    push_item(CMD_FLUSH, 8'hAA, 8'h55, 8'hAA);
    push_item(CMD_FLUSH, 8'h00, 8'h00, 8'h00);
    close_frame();

    // zero width and height clamp to 1x1, full-scale kernel saturates
    program_regs(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_item(CMD_PIXEL, 8'hFF, 8'h80, 8'h01);
    push_item(CMD_FLUSH, 8'h00, 8'h00, 8'h00);
    push_item(CMD_FLUSH, 8'h00, 8'h00, 8'h00);
    push_item(CMD_PIXEL, 8'h00, 8'h00, 8'h00);
    push_item(CMD_PIXEL, 8'h12, 8'h34, 8'h56);
    push_item(CMD_FLUSH, 8'hFF, 8'hFF, 8'hFF);
    close_frame();

    // height shrinks mid-frame so the position runs past the end and restarts
    program_regs(16'd2, 16'd5, 16'h0000, 16'd20000, 16'hFFFF);
    repeat (5) push_item(CMD_PIXEL, pick_level(), pick_level(), pick_level());
    settle();
    set_reg(REG_IMAGE_HEIGHT, 16'd1);
    end_writes();
    push_item(CMD_PIXEL, 8'h77, 8'h88, 8'h99);
    settle();
    push_frame(2, 1);
    close_frame();

    random_start = pix_queued;
    while (pix_queued - random_start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: w_pick = 16'($urandom_range(1, 8));
        6, 7: w_pick = 16'($urandom_range(9, 24));
        8: w_pick = 16'($urandom_range(25, 64));
        default: w_pick = 16'($urandom_range(0, 1));
      endcase
      h_pick = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(7, 12))
                                           : 16'($urandom_range(0, 6));
      program_regs(w_pick, h_pick, pick_coef(), pick_coef(), pick_coef());
      src_mode = idle_mode_e'($urandom_range(0, 2));
      snk_mode = idle_mode_e'($urandom_range(0, 2));
      frames = $urandom_range(1, 4);
      repeat (frames) begin
        push_frame(eff_width(), eff_height());
        // stray transfers knock the following frames out of step
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3))
            push_item(1'($urandom_range(0, 1)), pick_level(), pick_level(), pick_level());
      end
      close_frame();
    end

    // oversized height register clamps to the full height
    src_mode = IDLE_SOME;
    snk_mode = IDLE_NONE;
    program_regs(16'd1, 16'd2047, pick_coef(), pick_coef(), pick_coef());
    push_frame(eff_width(), eff_height());
    close_frame();

    if (filtered_expected.size() != 0) begin
      $error("%0d filtered pixels never arrived", filtered_expected.size());
      fail_count++;
    end
    $display("covered %0d input transfers, %0d filtered pixels checked, %0d frames closed",
             pix_taken, pixels_checked, frames_seen);
    $display("over %0d register setups, frames from 1x1 up to 64 wide or clamped %0d high",
             setups, MAX_HEIGHT);
    if (fail_count == 0) begin
      $display("gaussian_blur_3x3_rgb_unit test passed");
    end else begin
      $display("gaussian_blur_3x3_rgb_unit test failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("gaussian_blur_3x3_rgb_unit test failed");
    $finish;
  end

endmodule

/* gaussian_blur_3x3_rgb_unit.f */
rtl/gb3_pkg.sv
rtl/gb3_in_if.sv
rtl/gb3_out_if.sv
rtl/gb3_ram.sv
rtl/gb3_ctrl.sv
rtl/gb3_window.sv
rtl/gb3_mac.sv
rtl/gaussian_blur_3x3_rgb_unit.sv
tb/tb_gaussian_blur_3x3_rgb_unit.sv
